// ----- sv/two_class_priority_queue_macros.svh -----
// Assertion macros for the two-class priority queue checker.
`ifndef TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TCPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TCPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tcpq_pkg.sv -----
// Shared types and constants of the two-class priority queue.
package tcpq_pkg;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_SERVE    = 2'd1;
    localparam logic [1:0] OP_WITHDRAW = 2'd2;
    localparam logic [1:0] OP_QUERY    = 2'd3;

    localparam logic [7:0] THRESHOLD_RESET = 8'd60;
    localparam logic [8:0] AGE_ABSENT      = 9'h1FF;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  age;
    } tcpq_entry_t;

    typedef struct packed {
        logic        success;
        logic [31:0] served_id;
        logic [8:0]  found_age;
        logic [4:0]  entry_count;
    } tcpq_result_t;

endpackage

// ----- sv/tcpq_ram.sv -----
// Slot store: one write port, one registered read port.
module tcpq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  tcpq_pkg::tcpq_entry_t wdata,
    input  logic [AW-1:0]        raddr,
    output tcpq_pkg::tcpq_entry_t rdata
);
    import tcpq_pkg::*;

    tcpq_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/tcpq_seq.sv -----
// Sequencer: id search, slot shifting and result build over the slot store.
module tcpq_seq #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   idle,
    input  logic [1:0]             op,
    input  logic [31:0]            id,
    input  logic [8:0]             age,
    input  logic [7:0]             threshold,
    output logic                   mem_we,
    output logic [AW-1:0]          mem_waddr,
    output tcpq_pkg::tcpq_entry_t  mem_wdata,
    output logic [AW-1:0]          mem_raddr,
    input  tcpq_pkg::tcpq_entry_t  mem_rdata,
    output logic                   res_valid,
    input  logic                   res_ready,
    output tcpq_pkg::tcpq_result_t res
);
    import tcpq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SEARCH   = 6'b000010,
        S_SHIFT_DN = 6'b000100,
        S_SHIFT_UP = 6'b001000,
        S_PLACE    = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pref_reg, pref_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic          pend_reg, pend_next;
    logic          ok_reg, ok_next;
    logic [31:0]   sid_reg, sid_next;
    logic [8:0]    fage_reg, fage_next;

    logic [1:0]    op_reg;
    logic [31:0]   id_reg;
    logic [8:0]    age_reg;

    logic [CW-1:0] idx_inc, idx_dec, pos_inc;
    logic          match, preferred;
    logic [CW+4:0] count_wide;

    assign idx_inc    = idx_reg + 1'b1;
    assign idx_dec    = idx_reg - 1'b1;
    assign pos_inc    = pos_reg + 1'b1;
    assign match      = (op_reg == OP_SERVE) || (mem_rdata.id == id_reg);
    assign preferred  = age_reg[7:0] >= threshold;
    assign count_wide = {5'd0, count_reg};

    assign idle      = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res       = '{success: ok_reg, served_id: sid_reg, found_age: fage_reg,
                         entry_count: count_wide[4:0]};

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        pref_next  = pref_reg;
        wa_next    = wa_reg;
        pend_next  = pend_reg;
        ok_next    = ok_reg;
        sid_next   = sid_reg;
        fage_next  = fage_reg;
        mem_we     = 1'b0;
        mem_waddr  = wa_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ok_next   = 1'b0;
                    sid_next  = '0;
                    fage_next = '0;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    if (op == OP_INSERT && (age[8] || count_reg == CW'(DEPTH)))
                    begin
                        state_next = S_DONE;
                    end
                    else if (op == OP_SERVE && count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (pend_reg && match)
                begin
                    pend_next = 1'b0;
                    case (op_reg) inside
                        OP_QUERY:
                        begin
                            ok_next    = 1'b1;
                            fage_next  = {1'b0, mem_rdata.age};
                            state_next = S_DONE;
                        end
                        OP_SERVE, OP_WITHDRAW:
                        begin
                            ok_next = 1'b1;
                            if (op_reg == OP_SERVE)
                            begin
                                sid_next = mem_rdata.id;
                            end
                            idx_next   = pos_inc;
                            state_next = S_SHIFT_DN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
                else if (idx_reg < count_reg)
                begin
                    pos_next  = idx_reg;
                    idx_next  = idx_inc;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    case (op_reg)
                        OP_QUERY:
                        begin
                            fage_next  = AGE_ABSENT;
                            state_next = S_DONE;
                        end
                        OP_INSERT:
                        begin
                            if (preferred)
                            begin
                                pos_next   = pref_reg;
                                idx_next   = count_reg;
                                state_next = S_SHIFT_UP;
                            end
                            else
                            begin
                                pos_next   = count_reg;
                                state_next = S_PLACE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SHIFT_DN:
            begin
                mem_we = pend_reg;
                if (idx_reg < count_reg)
                begin
                    wa_next   = idx_dec[AW-1:0];
                    idx_next  = idx_inc;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        if (pos_reg < pref_reg)
                        begin
                            pref_next = pref_reg - 1'b1;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_SHIFT_UP:
            begin
                mem_we    = pend_reg;
                mem_raddr = idx_dec[AW-1:0];
                if (idx_reg > pos_reg)
                begin
                    wa_next   = idx_reg[AW-1:0];
                    idx_next  = idx_dec;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_PLACE;
                    end
                end
            end
            S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[AW-1:0];
                mem_wdata  = '{id: id_reg, age: age_reg[7:0]};
                count_next = count_reg + 1'b1;
                if (preferred)
                begin
                    pref_next = pref_reg + 1'b1;
                end
                ok_next    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pref_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pref_reg  <= pref_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        wa_reg   <= wa_next;
        ok_reg   <= ok_next;
        sid_reg  <= sid_next;
        fage_reg <= fage_next;
        if (start && idle)
        begin
            op_reg  <= op;
            id_reg  <= id;
            age_reg <= age;
        end
    end

endmodule

// ----- sv/two_class_priority_queue.sv -----
// Two-class priority queue: a bounded ordered store with unique ids.
//
// Request channel: in_valid/in_ready carry operation, person_id and person_age.
// Result channel: out_valid/out_ready carry success, served_id, found_age and
// entry_count; every request yields exactly one result word, in order.
// Configuration: cfg_wr_en writes cfg_wr_data into the age threshold at once.
//
// One request is in flight at a time; in_ready is high only while idle.
// The single read port of the slot store walks one slot per cycle: an id
// search reads the stored slots in turn, and a removal or a preferential
// insert then moves the trailing slots at one slot per cycle. A rejected
// insert (age bit 8 set or queue full) and a serve on an empty queue skip
// the search and go straight to the result; the next request is taken only
// after the sequencer has handed its result on and gone back to idle.
// A finished result sits in an output register; the next request is taken
// while it waits. If the receiver stalls, the following result waits in the
// sequencer and no further request is accepted until it moves on.
// Reset empties the queue (both class counts to zero) and sets the threshold
// to 60; slot contents need no clearing.
module two_class_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] person_id,
    input  logic [8:0]  person_age,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        success,
    output logic [31:0] served_id,
    output logic [8:0]  found_age,
    output logic [4:0]  entry_count,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);
    import tcpq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]   threshold_reg;
    logic         out_valid_reg;
    tcpq_result_t out_reg;

    logic          seq_idle;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    tcpq_entry_t   mem_wdata;
    tcpq_entry_t   mem_rdata;
    logic          res_valid;
    logic          res_ready;
    tcpq_result_t  res;

    assign in_ready  = seq_idle;
    assign res_ready = !out_valid_reg || out_ready;

    tcpq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcpq_seq #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid),
        .idle      (seq_idle),
        .op        (operation),
        .id        (person_id),
        .age       (person_age),
        .threshold (threshold_reg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign success     = out_reg.success;
    assign served_id   = out_reg.served_id;
    assign found_age   = out_reg.found_age;
    assign entry_count = out_reg.entry_count;

endmodule

// ----- sv/tcpq_checker.sv -----
// Port-level checker for the two-class priority queue, with its bind.
`include "two_class_priority_queue_macros.svh"

module tcpq_port_assert (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        success,
    input logic [31:0] served_id,
    input logic [8:0]  found_age
);

    logic        accepted;
    logic        out_stall;
    logic        served_set;
    logic        age_set;
    logic [41:0] out_word;

    assign accepted   = in_valid && in_ready;
    assign out_stall  = out_valid && !out_ready;
    assign served_set = out_valid && served_id != 32'd0;
    assign age_set    = out_valid && found_age != 9'd0 && found_age != 9'h1FF;
    assign out_word   = {success, served_id, found_age};

    `TCPQ_ASSERT_NEXT(a_busy_after_accept, accepted, !in_ready, "request taken while busy")
    `TCPQ_ASSERT_NOW(a_served_needs_ok, served_set, success, "served id on failed word")
    `TCPQ_ASSERT_NOW(a_age_needs_ok, age_set, success, "age on failed word")
    `TCPQ_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "result word dropped")

endmodule

bind two_class_priority_queue tcpq_port_assert u_tcpq_port_assert (.*);
